[hw/rtl/assert_macros.svh]
// assertion macros shared by the conversion unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ITFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ITFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/itfc_pkg.sv]
// types and constants of the integer to float conversion unit
package itfc_pkg;

  localparam int unsigned SGL_MANT_BITS = 23;
  localparam int unsigned DBL_MANT_BITS = 52;
  localparam logic [7:0]  SGL_BIAS      = 8'd127;
  localparam logic [10:0] DBL_BIAS      = 11'd1023;
  localparam logic [63:0] MOST_NEG_64   = 64'h8000_0000_0000_0000;

  // input transaction
  typedef struct packed {
    logic [63:0] int_value;
    logic [3:0]  source_bytes;
    logic        is_signed;
    logic        to_double;
    logic        check_errors;
  } itfc_in_t;

  // output transaction
  typedef struct packed {
    logic [63:0] float_bits;
    logic        status;
  } itfc_out_t;

  // index of the highest set bit of a 16-bit group (0 when empty)
  function automatic logic [3:0] itfc_top16(input logic [15:0] v);
    logic [3:0] p;
    p = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (v[k]) begin
        p = 4'(k);
      end
    end
    return p;
  endfunction

endpackage

[hw/rtl/integer_to_float_convert_unit.sv]
// integer to ieee-754 single/double conversion unit, truncating, five-stage pipeline
//
// Converts a 1 to 8 byte integer, signed or unsigned, to its single or double
// encoding with truncation of the mantissa. One transaction is accepted per
// cycle unless rsp_ready stalls the pipeline. Stage one clamps the width,
// sign-extends and takes the magnitude (a 64-bit negate), stages two and three
// find the leading one in 16-bit groups and then across groups, stage four
// normalizes with a 64-bit left shift, and stage five assembles the encoding
// and the status (lost precision or most negative 64-bit input) into the output
// register. Every stage holds its transaction while the stage after it is full
// and stalled, so bubbles are squeezed out and nothing is lost or repeated.
module integer_to_float_convert_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  itfc_pkg::itfc_in_t  req_item,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output itfc_pkg::itfc_out_t rsp_item
);
  import itfc_pkg::*;

  // stage valid bits and ready chain
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !v5 || rsp_ready;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req_ready = rdy1;

  // stage 1: clamp width, sign-extend, magnitude
  logic [3:0]  nb;
  logic        sign_bit;
  logic        neg_next;
  logic [63:0] val_ext;
  logic [63:0] mag_next;
  logic        minneg_next;

  always_comb begin
    if (req_item.source_bytes == 4'd0) begin
      nb = 4'd1;
    end else if (req_item.source_bytes > 4'd8) begin
      nb = 4'd8;
    end else begin
      nb = req_item.source_bytes;
    end
    case (nb)
      4'd1:    sign_bit = req_item.int_value[7];
      4'd2:    sign_bit = req_item.int_value[15];
      4'd3:    sign_bit = req_item.int_value[23];
      4'd4:    sign_bit = req_item.int_value[31];
      4'd5:    sign_bit = req_item.int_value[39];
      4'd6:    sign_bit = req_item.int_value[47];
      4'd7:    sign_bit = req_item.int_value[55];
      default: sign_bit = req_item.int_value[63];
    endcase
    neg_next = req_item.is_signed && sign_bit;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) begin
        val_ext[i*8 +: 8] = req_item.int_value[i*8 +: 8];
      end else begin
        val_ext[i*8 +: 8] = {8{neg_next}};
      end
    end
    mag_next    = neg_next ? (64'd0 - val_ext) : val_ext;
    minneg_next = req_item.check_errors && neg_next && (val_ext == MOST_NEG_64);
  end

  logic [63:0] mag1;
  logic        neg1, dbl1, chk1, minneg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= req_valid;
    end
    if (rdy1 && req_valid) begin
      mag1    <= mag_next;
      neg1    <= neg_next;
      dbl1    <= req_item.to_double;
      chk1    <= req_item.check_errors;
      minneg1 <= minneg_next;
    end
  end

  // stage 2: leading one inside each 16-bit group
  logic [63:0] mag2;
  logic        neg2, dbl2, chk2, minneg2;
  logic [3:0]  grp_nz2;
  logic [3:0]  grp_idx2 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      mag2    <= mag1;
      neg2    <= neg1;
      dbl2    <= dbl1;
      chk2    <= chk1;
      minneg2 <= minneg1;
      for (int g = 0; g < 4; g++) begin
        grp_nz2[g]  <= |mag1[g*16 +: 16];
        grp_idx2[g] <= itfc_top16(mag1[g*16 +: 16]);
      end
    end
  end

  // stage 3: combine groups into the leading-one position
  logic [5:0] top_next;
  always_comb begin
    if (grp_nz2[3]) begin
      top_next = {2'd3, grp_idx2[3]};
    end else if (grp_nz2[2]) begin
      top_next = {2'd2, grp_idx2[2]};
    end else if (grp_nz2[1]) begin
      top_next = {2'd1, grp_idx2[1]};
    end else begin
      top_next = {2'd0, grp_idx2[0]};
    end
  end

  logic [63:0] mag3;
  logic        neg3, dbl3, chk3, minneg3, zero3;
  logic [5:0]  top3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      mag3    <= mag2;
      neg3    <= neg2;
      dbl3    <= dbl2;
      chk3    <= chk2;
      minneg3 <= minneg2;
      zero3   <= ~|grp_nz2;
      top3    <= top_next;
    end
  end

  // stage 4: normalize so the leading one sits at bit 63
  logic [63:0] norm4;
  logic        neg4, dbl4, chk4, minneg4, zero4;
  logic [5:0]  top4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4 && v3) begin
      norm4   <= mag3 << (~top3);
      neg4    <= neg3;
      dbl4    <= dbl3;
      chk4    <= chk3;
      minneg4 <= minneg3;
      zero4   <= zero3;
      top4    <= top3;
    end
  end

  // stage 5: assemble encoding and status
  logic [10:0] dbl_expo;
  logic [7:0]  sgl_expo;
  logic        lost;
  itfc_out_t   res_next;

  always_comb begin
    dbl_expo = {5'd0, top4} + DBL_BIAS;
    sgl_expo = {2'd0, top4} + SGL_BIAS;
    if (dbl4) begin
      lost = |norm4[62-DBL_MANT_BITS:0];
    end else begin
      lost = |norm4[62-SGL_MANT_BITS:0];
    end
    if (zero4) begin
      res_next.float_bits = 64'd0;
    end else if (dbl4) begin
      res_next.float_bits = {neg4, dbl_expo, norm4[62 -: DBL_MANT_BITS]};
    end else begin
      res_next.float_bits = {32'd0, neg4, sgl_expo, norm4[62 -: SGL_MANT_BITS]};
    end
    res_next.status = minneg4 || (chk4 && !zero4 && lost);
  end

  logic dbl5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
    if (rdy5 && v4) begin
      rsp_item <= res_next;
      dbl5     <= dbl4;
    end
  end

  assign rsp_valid = v5;

  // checks on internal pipeline behavior
  `include "assert_macros.svh"

  `ITFC_ASSERT_NOW(a_norm_msb, v4 && !zero4, norm4[63], "normalized magnitude lacks leading one")
  `ITFC_ASSERT_NOW(a_sgl_upper, v5 && !dbl5, rsp_item.float_bits[63:32] == 32'd0, "single result has upper bits set")
  `ITFC_ASSERT_NEXT(a_s1_hold, v1 && !rdy2, v1 && $stable(mag1) && $stable(neg1), "stalled stage one transaction changed")

endmodule
